/* rtl/interrupt_vector_slot_dispatcher_top_defines.svh */
// assertion macros for the interrupt vector slot dispatcher
`ifndef INTERRUPT_VECTOR_SLOT_DISPATCHER_TOP_DEFINES_SVH
`define INTERRUPT_VECTOR_SLOT_DISPATCHER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IVSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in a later cycle
`define IVSD_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

/* rtl/ivsd_pkg.sv */
// shared types and codes of the interrupt vector slot dispatcher
package ivsd_pkg;

  localparam int unsigned NumSlotsDef   = 16;
  localparam int unsigned MaxSourcesDef = 32;

  localparam logic [1:0] OP_REG    = 2'd0;
  localparam logic [1:0] OP_UNREG  = 2'd1;
  localparam logic [1:0] OP_EVENT  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_NO_RES  = 2'd3;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_VECTORED = 2'd1;
  localparam logic [1:0] KIND_SHARED   = 2'd2;
  localparam logic [1:0] KIND_SPURIOUS = 2'd3;

  localparam logic [7:0] SHARE_MAX = 8'd255;

  typedef enum logic [1:0] {
    PH_FIQ,
    PH_VEC,
    PH_IRQ
  } phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  source;
    logic        handler_given;
    logic [31:0] irq_pending;
    logic [31:0] fiq_pending;
    logic        vector_flag;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic       slot_valid;
    logic [1:0] dispatch_kind;
    logic [4:0] dispatch_source;
    logic       disable_request;
    logic       last;
  } result_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    logic   scan;
    phase_e phase;
    logic   flush;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

/* rtl/ivsd_ctrl.sv */
// controller state machine: sequences register ops and the three event passes
module ivsd_ctrl import ivsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e state_q;
  phase_e phase_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_FIQ;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            busy_q  <= 1'b1;
            phase_q <= PH_FIQ;
            state_q <= (op_i == OP_EVENT) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            case (phase_q)
              PH_FIQ:  phase_q <= PH_VEC;
              PH_VEC:  phase_q <= PH_IRQ;
              default: state_q <= S_FLUSH;
            endcase
          end
        end
        S_FLUSH: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    cmd_o.load  = (state_q == S_IDLE) && start;
    cmd_o.exec  = (state_q == S_EXEC);
    cmd_o.scan  = (state_q == S_SCAN);
    cmd_o.flush = (state_q == S_FLUSH);
  end

  assign busy = busy_q;

endmodule

/* rtl/ivsd_datapath.sv */
// slot table, source map, share counts, scan counter and result registers
module ivsd_datapath import ivsd_pkg::*; #(
  parameter int unsigned NUM_SLOTS   = NumSlotsDef,
  parameter int unsigned MAX_SOURCES = MaxSourcesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  logic       cfg_valid_i,
  input  logic [5:0] cfg_data_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic       result_valid_o,
  output result_t    result_o
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned SRC_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  item_t       item_q;
  logic [31:0] irq_q;
  logic [5:0]  cnt_q;
  logic [5:0]  num_q;
  logic        held_v_q;
  result_t     held_q;
  logic        out_valid_q;
  logic        out_valid_d;
  result_t     out_q;

  logic [NUM_SLOTS-1:0]   active_q;
  logic [4:0]             owner_q [NUM_SLOTS];
  logic [MAX_SOURCES-1:0] mapped_q;
  logic [SLOT_W-1:0]      src_slot_q [MAX_SOURCES];
  logic [7:0]             share_q [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] shared_q;

  logic [5:0]        ns;
  logic [5:0]        limit;
  logic              done;
  logic              step;
  logic [SRC_W-1:0]  src_idx;
  logic [SLOT_W-1:0] slot_idx;
  logic [4:0]        owner;
  logic              src_ok;
  logic              arg_ok;
  logic              mapped_s;
  logic [7:0]        share_s;
  logic [SLOT_W-1:0] ss;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              alloc;
  logic [SLOT_W+3:0] free_w;
  logic [SLOT_W+3:0] ss_w;
  logic [SLOT_W+3:0] idx_w;
  result_t           res_exec;
  result_t           res_flush;
  result_t           cand;
  logic              hit;

  assign ns       = (num_q > 6'(MAX_SOURCES)) ? 6'(MAX_SOURCES) : num_q;
  assign limit    = (cmd_i.phase == PH_VEC) ? 6'(NUM_SLOTS) : ns;
  assign done     = (cnt_q == limit);
  assign step     = cmd_i.scan && !done;
  assign src_idx  = cmd_i.scan ? cnt_q[SRC_W-1:0] : item_q.source[SRC_W-1:0];
  assign slot_idx = cnt_q[SLOT_W-1:0];
  assign owner    = owner_q[slot_idx];
  assign src_ok   = (item_q.source < ns);
  assign arg_ok   = src_ok && item_q.handler_given;
  assign mapped_s = mapped_q[src_idx];
  assign share_s  = share_q[src_idx];
  assign ss       = src_slot_q[src_idx];
  assign alloc    = cmd_i.exec && (item_q.op == OP_REG) && arg_ok && !mapped_s && free_found;
  assign free_w   = {4'b0, free_idx};
  assign ss_w     = {4'b0, ss};
  assign idx_w    = {4'b0, slot_idx};

  assign sts_o.scan_done = done;

  // a found dispatch pushes out the one held before it
  assign out_valid_d = cmd_i.exec || cmd_i.flush || (step && hit && held_v_q);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    res_exec        = '0;
    res_exec.last   = 1'b1;
    res_exec.status = ST_BAD_ARG;
    case (item_q.op)
      OP_REG: begin
        if (!arg_ok) begin
          res_exec.status = ST_BAD_ARG;
        end else if (mapped_s) begin
          res_exec.status = (share_s != 8'd0) ? ST_OK : ST_BUSY;
        end else if (free_found) begin
          res_exec.status     = ST_OK;
          res_exec.slot       = free_w[3:0];
          res_exec.slot_valid = 1'b1;
        end else begin
          res_exec.status = ST_NO_RES;
        end
      end
      OP_UNREG: res_exec.status = src_ok ? ST_OK : ST_BAD_ARG;
      default:  res_exec.status = ST_BAD_ARG;
    endcase
  end

  // final result of an event: the held dispatch, or a none result
  always_comb begin
    res_flush        = '0;
    res_flush.status = ST_OK;
    if (held_v_q) begin
      res_flush = held_q;
    end
    res_flush.last = 1'b1;
  end

  // dispatch candidate at the current scan position
  always_comb begin
    cand        = '0;
    cand.status = ST_OK;
    hit         = 1'b0;
    case (cmd_i.phase)
      PH_FIQ: begin
        hit                  = item_q.fiq_pending[cnt_q[4:0]];
        cand.dispatch_source = cnt_q[4:0];
        if (mapped_s) begin
          cand.dispatch_kind = KIND_VECTORED;
          cand.slot          = ss_w[3:0];
          cand.slot_valid    = 1'b1;
        end else if (shared_q[src_idx]) begin
          cand.dispatch_kind = KIND_SHARED;
        end else begin
          cand.dispatch_kind   = KIND_SPURIOUS;
          cand.disable_request = 1'b1;
        end
      end
      PH_VEC: begin
        hit                  = item_q.vector_flag && active_q[slot_idx] && irq_q[owner];
        cand.dispatch_source = owner;
        cand.dispatch_kind   = KIND_VECTORED;
        cand.slot            = idx_w[3:0];
        cand.slot_valid      = 1'b1;
      end
      PH_IRQ: begin
        hit                  = irq_q[cnt_q[4:0]];
        cand.dispatch_source = cnt_q[4:0];
        if (shared_q[src_idx]) begin
          cand.dispatch_kind = KIND_SHARED;
        end else begin
          cand.dispatch_kind   = KIND_SPURIOUS;
          cand.disable_request = 1'b1;
        end
      end
      default: hit = 1'b0;
    endcase
  end

  // control: config, scan counter, result strobes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= 6'd32;
      cnt_q       <= '0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        num_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        cnt_q    <= '0;
        held_v_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        cnt_q <= done ? 6'd0 : cnt_q + 6'd1;
        if (step && hit) begin
          held_v_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        held_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
      irq_q  <= item_i.irq_pending;
    end
    if (cmd_i.exec) begin
      out_q <= res_exec;
    end
    if (step && hit) begin
      held_q <= cand;
      out_q  <= held_q;
      if (cmd_i.phase == PH_VEC) begin
        irq_q[owner] <= 1'b0;
      end
    end
    if (cmd_i.flush) begin
      out_q <= res_flush;
    end
    if (alloc) begin
      owner_q[free_idx]   <= item_q.source[4:0];
      src_slot_q[src_idx] <= free_idx;
    end
  end

  // slot table and source map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      mapped_q <= '0;
      shared_q <= '0;
      for (int i = 0; i < MAX_SOURCES; i++) begin
        share_q[i] <= 8'd0;
      end
    end else if (cmd_i.exec) begin
      case (item_q.op)
        OP_REG: begin
          if (arg_ok) begin
            if (mapped_s) begin
              if (share_s != 8'd0) begin
                if (share_s != SHARE_MAX) begin
                  share_q[src_idx] <= share_s + 8'd1;
                end
                shared_q[src_idx] <= 1'b1;
              end
            end else if (free_found) begin
              active_q[free_idx] <= 1'b1;
              mapped_q[src_idx]  <= 1'b1;
              share_q[src_idx]   <= 8'd1;
            end
          end
        end
        OP_UNREG: begin
          if (src_ok) begin
            if (share_s > 8'd1) begin
              share_q[src_idx]  <= share_s - 8'd1;
              shared_q[src_idx] <= 1'b0;
            end else begin
              if (mapped_s) begin
                active_q[ss] <= 1'b0;
              end
              mapped_q[src_idx] <= 1'b0;
              share_q[src_idx]  <= 8'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

/* rtl/interrupt_vector_slot_dispatcher_top.sv */
// top level of the interrupt vector slot dispatcher
// Usage:
// An item is taken when start is high and busy is low. Register and
// unregister items pass through the exec state, and their one result is
// registered from it; busy stays high for one cycle, in which no item is taken.
// An interrupt event scans one position per cycle with one shared counter:
// the FIQ pass over the implemented sources, the vectored pass over all
// NUM_SLOTS slots and the IRQ pass over the sources; each pass closes with
// a step when the counter reaches its limit, and then the flush state ends
// the item. A found dispatch is held until the next one is found
// or until the flush state, so results trail the scan by one dispatch.
// Each result is on result_o for one cycle under result_valid_o and is
// taken at the end of that cycle; the receiver cannot stall. last marks the
// final result of an item.
// The num_sources register is written through cfg_valid_i/cfg_data_i, always
// ready; the user must write it only while busy is low, the block does not enforce it.
// Reset frees all slots, unmaps all sources, clears share counts and sets
// num_sources to 32.
`include "interrupt_vector_slot_dispatcher_top_defines.svh"
module interrupt_vector_slot_dispatcher_top import ivsd_pkg::*; #(
  parameter int unsigned NUM_SLOTS   = NumSlotsDef,
  parameter int unsigned MAX_SOURCES = MaxSourcesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  item_t      item_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  output logic       result_valid_o,
  output result_t    result_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ivsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (item_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  ivsd_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_SOURCES (MAX_SOURCES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `IVSD_ASSERT_IMPL(a_disable_spurious, result_valid_o && result_o.disable_request, result_o.dispatch_kind == KIND_SPURIOUS, "disable request on a non-spurious dispatch")
  `IVSD_ASSERT_DLY2(a_op_result, start && !busy && item_i.op != OP_EVENT, result_valid_o && result_o.last, "register op result missing")
  `IVSD_ASSERT_IMPL(a_done_last, $fell(busy), result_valid_o && result_o.last, "item ended without a final result")

endmodule
